// ===== sv/spg_pkg.sv =====
// Shared types, codes and constants of the sensor plausibility gate.
package spg_pkg;

    // Commands carried in s_tuser
    localparam logic [1:0] CMD_VALIDATE = 2'd0;
    localparam logic [1:0] CMD_RECORD   = 2'd1;
    localparam logic [1:0] CMD_CLEAR    = 2'd2;

    // Result codes
    localparam logic [1:0] ST_VALID = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_RATE  = 2'd2;
    localparam logic [1:0] ST_STUCK = 2'd3;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_GATE_EN = 3'd0;
    localparam logic [2:0] REG_MIN     = 3'd1;
    localparam logic [2:0] REG_MAX     = 3'd2;
    localparam logic [2:0] REG_RATE    = 3'd3;
    localparam logic [2:0] REG_STUCK   = 3'd4;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int TIME_W   = 48;
    localparam int RATE_W   = 31;
    localparam int TMO_W    = 16;
    localparam int DIFF_W   = 33;
    localparam int MAG_W    = 32;
    localparam int LHS_W    = 42;           // |delta| * 1000 stays below 2^42
    localparam int DT_W     = 42;           // larger dt can never exceed the rate
    localparam int HALF_W   = DT_W / 2;
    localparam int PROD_W   = RATE_W + HALF_W;
    localparam int RHS_W    = PROD_W + HALF_W;
    localparam int TMO_MS_W = 26;           // timeout * 1000 stays below 2^26
    localparam int MS_W     = 10;

    localparam logic [MS_W-1:0] MS_PER_SEC = 10'd1000;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    // Requests that can be in flight: queue, multiply stage, output register
    localparam int OUT_CAP = QDEPTH + 2;

    typedef struct packed {
        logic                     gate_enabled;
        logic signed [DATA_W-1:0] range_lo;
        logic signed [DATA_W-1:0] range_hi;
        logic [RATE_W-1:0]        max_rate;
        logic [TMO_W-1:0]         stuck_limit_s;
    } cfg_t;

    // One classified request handed from front to back
    typedef struct packed {
        logic                     done;
        logic [1:0]               early_status;
        logic                     rate_chk;
        logic                     stuck_chk;
        logic signed [DIFF_W-1:0] diff;
        logic [DT_W-1:0]          dt;
        logic [TIME_W-1:0]        elapsed;
    } entry_t;

endpackage

// ===== sv/sensor_plausibility_gate.sv =====
// Top level of the sensor plausibility gate: range, rate and stuck checks.
//
// The gate grades Q16.16 sensor readings that carry millisecond timestamps.
// Each request on the s_ stream carries a command in s_tuser (validate,
// record or clear) and the reading and time in s_tdata; every request, of
// any command, yields exactly one result on the m_ stream, in request
// order, with the status in m_tdata[1:0] (valid, out of range, rate
// exceeded, stuck; valid for record, clear and the unused command). The
// gate takes one request per clock while the queue has room: the front
// end keeps the history of the last recorded reading and classifies each
// request in the cycle it is accepted, so a validate directly after a
// record already sees that record. A four-entry queue then feeds a
// two-stage back end (the rate and timeout multiplies, then the wide rate
// compare) whose last stage is the output register, and up to six
// requests may be in flight while m_tready is low.
// Registers are written through the APB port at byte address 4 * index
// and should only be changed while no request is in flight; there is no
// start-up sweep, the block is ready right after reset.
module sensor_plausibility_gate (
    input  logic                       aclk,
    input  logic                       aresetn,
    // request stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [1:0]                 s_tuser,   // [1:0] command
    input  logic [79:0]                s_tdata,   // [31:0] reading, [79:32] time_ms
    // result stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [1:0] status, [7:2] zero
    // configuration port
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spg_pkg::ADDR_W-1:0] paddr,
    input  logic [spg_pkg::DATA_W-1:0] pwdata,
    output logic [spg_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    spg_pkg::cfg_t   cfg;
    spg_pkg::entry_t push_entry;
    spg_pkg::entry_t pop_entry;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_empty;

    // Register file: gate enable, physical bounds, rate limit, stuck timeout
    spg_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Front end: accept, update history, classify; stall only on a full queue
    spg_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .cfg        (cfg),
        .q_full     (q_full),
        .push       (push),
        .push_entry (push_entry)
    );

    // Decouple the two halves so either can stall on its own
    spg_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .pop_entry  (pop_entry),
        .empty      (q_empty)
    );

    // Back end: finish the rate and stuck checks, hold results for the sink
    spg_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// ===== sv/spg_regs.sv =====
// APB configuration register file of the plausibility gate.
module spg_regs (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [spg_pkg::ADDR_W-1:0] paddr,
    input  logic [spg_pkg::DATA_W-1:0] pwdata,
    output logic [spg_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output spg_pkg::cfg_t              cfg
);

    spg_pkg::cfg_t cfg_reg;
    spg_pkg::cfg_t cfg_next;
    logic [2:0]    index;
    logic          wr_en;

    assign pready = 1'b1;
    assign index  = paddr[spg_pkg::ADDR_W-1:2];
    assign wr_en  = psel & penable & pwrite & pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (index)
                spg_pkg::REG_GATE_EN: cfg_next.gate_enabled = pwdata[0];
                spg_pkg::REG_MIN:     cfg_next.range_lo = pwdata;
                spg_pkg::REG_MAX:     cfg_next.range_hi = pwdata;
                spg_pkg::REG_RATE:    cfg_next.max_rate = pwdata[spg_pkg::RATE_W-1:0];
                spg_pkg::REG_STUCK:   cfg_next.stuck_limit_s = pwdata[spg_pkg::TMO_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (index)
            spg_pkg::REG_GATE_EN: prdata = {31'd0, cfg_reg.gate_enabled};
            spg_pkg::REG_MIN:     prdata = cfg_reg.range_lo;
            spg_pkg::REG_MAX:     prdata = cfg_reg.range_hi;
            spg_pkg::REG_RATE:    prdata = {1'b0, cfg_reg.max_rate};
            spg_pkg::REG_STUCK:   prdata = {16'd0, cfg_reg.stuck_limit_s};
            default:              prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gate_enabled  <= 1'b0;
            cfg_reg.range_lo      <= 32'sh8000_0000;
            cfg_reg.range_hi      <= 32'sh7FFF_FFFF;
            cfg_reg.max_rate      <= '0;
            cfg_reg.stuck_limit_s <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== sv/spg_front.sv =====
// Front end: accepts requests, keeps the history and classifies each request.
module spg_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [1:0]            s_tuser,   // [1:0] command
    input  logic [79:0]           s_tdata,   // [31:0] reading, [79:32] time_ms
    input  spg_pkg::cfg_t         cfg,
    input  logic                  q_full,
    output logic                  push,
    output spg_pkg::entry_t       push_entry
);

    logic                             has_history_reg, has_history_next;
    logic signed [spg_pkg::DATA_W-1:0] prev_reading_reg, prev_reading_next;
    logic [spg_pkg::TIME_W-1:0]       prev_time_reg, prev_time_next;
    logic [spg_pkg::TIME_W-1:0]       last_change_reg, last_change_next;

    logic signed [spg_pkg::DATA_W-1:0] reading;
    logic [spg_pkg::TIME_W-1:0]       time_ms;
    logic [spg_pkg::TIME_W-1:0]       dt_full;
    logic                             range_ok;
    logic                             accept;

    assign s_tready = !q_full;
    assign accept   = s_tvalid & s_tready;
    assign push     = accept;
    assign reading  = s_tdata[31:0];
    assign time_ms  = s_tdata[79:32];
    assign dt_full  = time_ms - prev_time_reg;
    assign range_ok = !(reading < cfg.range_lo) && !(reading > cfg.range_hi);

    always_comb begin
        push_entry.done         = 1'b1;
        push_entry.early_status = spg_pkg::ST_VALID;
        // a dt beyond 42 bits always satisfies the rate limit, so skip it
        push_entry.rate_chk     = (cfg.max_rate != '0) && (prev_time_reg != '0) &&
                                  (time_ms > prev_time_reg) &&
                                  (dt_full[spg_pkg::TIME_W-1:spg_pkg::DT_W] == '0);
        push_entry.stuck_chk    = (cfg.stuck_limit_s != '0) &&
                                  (reading == prev_reading_reg) &&
                                  (last_change_reg != '0) && (time_ms > last_change_reg);
        push_entry.diff         = {reading[31], reading} -
                                  {prev_reading_reg[31], prev_reading_reg};
        push_entry.dt           = dt_full[spg_pkg::DT_W-1:0];
        push_entry.elapsed      = time_ms - last_change_reg;
        if (s_tuser == spg_pkg::CMD_VALIDATE) begin
            if (!cfg.gate_enabled || !range_ok) begin
                push_entry.early_status = spg_pkg::ST_RANGE;
            end else if (has_history_reg) begin
                push_entry.done = 1'b0;
            end
        end
    end

    always_comb begin
        has_history_next  = has_history_reg;
        prev_reading_next = prev_reading_reg;
        prev_time_next    = prev_time_reg;
        last_change_next  = last_change_reg;
        if (accept) begin
            case (s_tuser)
                spg_pkg::CMD_RECORD: begin
                    if (reading != prev_reading_reg) begin
                        last_change_next = time_ms;
                    end
                    prev_reading_next = reading;
                    prev_time_next    = time_ms;
                    has_history_next  = 1'b1;
                end
                spg_pkg::CMD_CLEAR: begin
                    has_history_next  = 1'b0;
                    prev_reading_next = '0;
                    prev_time_next    = '0;
                    last_change_next  = '0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_history_reg  <= 1'b0;
            prev_reading_reg <= '0;
            prev_time_reg    <= '0;
            last_change_reg  <= '0;
        end else begin
            has_history_reg  <= has_history_next;
            prev_reading_reg <= prev_reading_next;
            prev_time_reg    <= prev_time_next;
            last_change_reg  <= last_change_next;
        end
    end

endmodule

// ===== sv/spg_fifo.sv =====
// Short request queue between the front end and the check pipeline.
module spg_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  spg_pkg::entry_t push_entry,
    output logic            full,
    input  logic            pop,
    output spg_pkg::entry_t pop_entry,
    output logic            empty
);

    spg_pkg::entry_t             slot_reg [spg_pkg::QDEPTH];
    logic [spg_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [spg_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [spg_pkg::QPTR_W:0]    count_reg, count_next;

    assign full      = (count_reg == (spg_pkg::QPTR_W+1)'(spg_pkg::QDEPTH));
    assign empty     = (count_reg == '0);
    assign pop_entry = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (spg_pkg::QPTR_W+1)'(push) - (spg_pkg::QPTR_W+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== sv/spg_back.sv =====
// Back end: rate and stuck checks in a multiply stage and a compare stage.
module spg_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  spg_pkg::cfg_t   cfg,
    input  logic            q_empty,
    input  spg_pkg::entry_t q_entry,
    output logic            q_pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata    // [1:0] status, [7:2] zero
);

    logic                          advance;
    logic [spg_pkg::MAG_W-1:0]     mag;
    logic [spg_pkg::TMO_MS_W-1:0]  stuck_limit_ms;

    // multiply stage
    logic                          b1_valid_reg, b1_valid_next;
    logic                          b1_done_reg;
    logic [1:0]                    b1_early_reg;
    logic                          b1_rate_chk_reg;
    logic                          b1_stuck_chk_reg;
    logic [spg_pkg::LHS_W-1:0]     b1_lhs_reg;
    logic [spg_pkg::PROD_W-1:0]    b1_plo_reg;
    logic [spg_pkg::PROD_W-1:0]    b1_phi_reg;
    logic                          b1_stuck_hit_reg;

    // compare stage / output register
    logic [spg_pkg::RHS_W-1:0]     rhs;
    logic                          rate_hit;
    logic [1:0]                    status_next;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    status_reg;

    assign advance  = !out_valid_reg || m_tready;
    assign q_pop    = advance && !q_empty;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, status_reg};

    assign mag = q_entry.diff[spg_pkg::DIFF_W-1] ?
                 spg_pkg::MAG_W'(-q_entry.diff) : q_entry.diff[spg_pkg::MAG_W-1:0];
    assign stuck_limit_ms = spg_pkg::TMO_MS_W'(cfg.stuck_limit_s) *
                            spg_pkg::TMO_MS_W'(spg_pkg::MS_PER_SEC);

    always_ff @(posedge aclk) begin
        if (advance) begin
            b1_done_reg      <= q_entry.done;
            b1_early_reg     <= q_entry.early_status;
            b1_rate_chk_reg  <= q_entry.rate_chk;
            b1_stuck_chk_reg <= q_entry.stuck_chk;
            b1_lhs_reg       <= spg_pkg::LHS_W'(mag) * spg_pkg::LHS_W'(spg_pkg::MS_PER_SEC);
            b1_plo_reg       <= spg_pkg::PROD_W'(cfg.max_rate) *
                                spg_pkg::PROD_W'(q_entry.dt[spg_pkg::HALF_W-1:0]);
            b1_phi_reg       <= spg_pkg::PROD_W'(cfg.max_rate) *
                                spg_pkg::PROD_W'(q_entry.dt[spg_pkg::DT_W-1:spg_pkg::HALF_W]);
            b1_stuck_hit_reg <= q_entry.elapsed > spg_pkg::TIME_W'(stuck_limit_ms);
        end
    end

    always_comb begin
        rhs      = {b1_phi_reg, {spg_pkg::HALF_W{1'b0}}} + spg_pkg::RHS_W'(b1_plo_reg);
        rate_hit = spg_pkg::RHS_W'(b1_lhs_reg) > rhs;
        if (b1_done_reg) begin
            status_next = b1_early_reg;
        end else if (b1_rate_chk_reg && rate_hit) begin
            status_next = spg_pkg::ST_RATE;
        end else if (b1_stuck_chk_reg && b1_stuck_hit_reg) begin
            status_next = spg_pkg::ST_STUCK;
        end else begin
            status_next = spg_pkg::ST_VALID;
        end
        b1_valid_next  = advance ? !q_empty : b1_valid_reg;
        out_valid_next = advance ? b1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            status_reg <= status_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            b1_valid_reg  <= b1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== sv/spg_checker.sv =====
// Port-level checks of the plausibility gate, bound to the top level.
module spg_checker (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       s_tvalid,
    input logic                       s_tready,
    input logic [1:0]                 s_tuser,
    input logic [79:0]                s_tdata,
    input logic                       m_tvalid,
    input logic                       m_tready,
    input logic [7:0]                 m_tdata,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic [spg_pkg::ADDR_W-1:0] paddr,
    input logic [spg_pkg::DATA_W-1:0] pwdata,
    input logic [spg_pkg::DATA_W-1:0] prdata,
    input logic                       pready
);

    logic       in_acc;
    logic       out_acc;
    logic [3:0] pending_reg, pending_next;

    assign in_acc  = s_tvalid & s_tready;
    assign out_acc = m_tvalid & m_tready;

    always_comb begin
        pending_next = pending_reg + 4'(in_acc) - 4'(out_acc);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    // Never a result without an outstanding request
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == 4'd0) |-> !m_tvalid)
        else $error("result shown with no request outstanding");

    // In-flight requests never exceed the pipeline's capacity
    a_capacity: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= 4'(spg_pkg::OUT_CAP))
        else $error("more requests in flight than the gate can hold");

    // A stalled result holds its value
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed or dropped");

    // Full pipeline with a stalled sink must push back on the source
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (pending_reg == 4'(spg_pkg::OUT_CAP) && !m_tready) |-> !s_tready)
        else $error("request accepted with no room left");

    // Padding bits of the result stay zero
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:2] == 6'd0))
        else $error("result padding not zero");

endmodule

bind sensor_plausibility_gate spg_checker u_spg_checker (.*);

// ===== tb/sv/sensor_plausibility_gate_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the sensor plausibility gate: directed and random traffic.
module sensor_plausibility_gate_tb;

    // The package names only the three real commands and five registers;
    // these cover the unused command and the unmapped register slots.
    localparam logic [1:0] CMD_UNUSED   = 2'd3;
    localparam logic [2:0] REG_SPARE_LO = 3'd5;
    localparam logic [2:0] REG_SPARE_HI = 3'd7;

    // Slack for the pipeline plus up to six requests held while stalled
    localparam int SETTLE_CYCLES = 12;

    typedef struct packed {
        logic                              valid;
        logic signed [spg_pkg::DATA_W-1:0] reading;
        logic [spg_pkg::TIME_W-1:0]        stamp;
        logic [spg_pkg::TIME_W-1:0]        change_stamp;
    } sensor_hist_t;

    logic                        aclk;
    logic                        aresetn  = 1'b0;
    logic                        s_tvalid = 1'b0;
    logic                        s_tready;
    logic [1:0]                  s_tuser  = '0;     // [1:0] command
    logic [79:0]                 s_tdata  = '0;     // [31:0] reading, [79:32] time_ms
    logic                        m_tvalid;
    logic                        m_tready = 1'b0;
    logic [7:0]                  m_tdata;           // [1:0] status, [7:2] zero
    logic                        psel     = 1'b0;
    logic                        penable  = 1'b0;
    logic                        pwrite   = 1'b0;
    logic [spg_pkg::ADDR_W-1:0]  paddr    = '0;
    logic [spg_pkg::DATA_W-1:0]  pwdata   = '0;
    logic [spg_pkg::DATA_W-1:0]  prdata;
    logic                        pready;

    // Shadow of the block: register copy and recorded history
    spg_pkg::cfg_t       gate_cfg = '{gate_enabled: 1'b0,
                                      range_lo: 32'sh8000_0000,
                                      range_hi: 32'sh7FFF_FFFF,
                                      max_rate: '0,
                                      stuck_limit_s: '0};
    sensor_hist_t        hist = '0;

    logic [1:0]          pending_status[$];
    int                  mismatch_count = 0;
    logic [1:0]          oldest_status;

    // Traffic shaping knobs, changed per phase
    int                  stall_pct  = 0;
    int                  gap_max    = 0;
    int                  burst_left = 0;
    int                  stall_left = 0;
    logic [spg_pkg::TIME_W-1:0] sensor_clock_ms = '0;

    sensor_plausibility_gate u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard stop: far beyond the slowest legal run
    initial begin
        #2_000_000;
        $display("sensor_plausibility_gate_tb: done, errors");
        $finish;
    end

    // Receiver: hold m_tready low for random runs; stall_pct = 0 never stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left <= $urandom_range(0, 6);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare every accepted result with the oldest predicted status
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_status.size() == 0) begin
                mismatch_count++;
                $display("%0t: result with none expected, expected none, actual status %0d",
                         $time, m_tdata[1:0]);
            end else begin
                oldest_status = pending_status.pop_front();
                if (m_tdata !== {6'b0, oldest_status}) begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d, actual m_tdata 0x%02h",
                             $time, oldest_status, m_tdata);
                end
            end
        end
    end

    // Grade one request the way the gate must, and advance the history
    function automatic logic [1:0] grade_request(
            input logic [1:0] cmd,
            input logic signed [spg_pkg::DATA_W-1:0] rd,
            input logic [spg_pkg::TIME_W-1:0] tms);
        logic [1:0]         grade;
        logic signed [32:0] delta;
        logic [95:0]        moved;
        logic [95:0]        allowed;
        grade   = spg_pkg::ST_VALID;
        delta   = rd - hist.reading;
        if (delta < 0)
            delta = -delta;
        // Cross-multiplied rate test: |delta| * 1000 against max_rate * dt
        moved   = 96'(delta) * 96'd1000;
        allowed = 96'(gate_cfg.max_rate) * 96'(tms - hist.stamp);
        case (cmd)
            spg_pkg::CMD_VALIDATE: begin
                if (!gate_cfg.gate_enabled || rd < $signed(gate_cfg.range_lo) ||
                    rd > $signed(gate_cfg.range_hi)) begin
                    grade = spg_pkg::ST_RANGE;
                end else if (!hist.valid) begin
                    grade = spg_pkg::ST_VALID;
                end else if (gate_cfg.max_rate != 0 && hist.stamp != 0 &&
                             tms > hist.stamp && moved > allowed) begin
                    grade = spg_pkg::ST_RATE;
                end else if (gate_cfg.stuck_limit_s != 0 && rd == hist.reading &&
                             hist.change_stamp != 0 && tms > hist.change_stamp &&
                             64'(tms - hist.change_stamp) >
                             64'(gate_cfg.stuck_limit_s) * 64'd1000) begin
                    grade = spg_pkg::ST_STUCK;
                end
            end
            spg_pkg::CMD_RECORD: begin
                if (rd != hist.reading)
                    hist.change_stamp = tms;
                hist.reading = rd;
                hist.stamp   = tms;
                hist.valid   = 1'b1;
            end
            spg_pkg::CMD_CLEAR: hist = '0;
            default: ;
        endcase
        return grade;
    endfunction

    // Drop tvalid and hold until every predicted result has come back
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (pending_status.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Send one request; the sender idles between bursts of random length
    task automatic send_request(input logic [1:0] cmd,
                                input logic signed [spg_pkg::DATA_W-1:0] rd,
                                input logic [spg_pkg::TIME_W-1:0] tms);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {tms, rd};
        do
            @(posedge aclk);
        while (!s_tready);
        pending_status.push_back(grade_request(cmd, rd, tms));
    endtask

    // APB write of one register, only with no request in flight
    task automatic write_reg(input logic [2:0] idx, input logic [spg_pkg::DATA_W-1:0] value);
        drain_results();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do
            @(posedge aclk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            spg_pkg::REG_GATE_EN: gate_cfg.gate_enabled  = value[0];
            spg_pkg::REG_MIN:     gate_cfg.range_lo      = value;
            spg_pkg::REG_MAX:     gate_cfg.range_hi      = value;
            spg_pkg::REG_RATE:    gate_cfg.max_rate      = value[spg_pkg::RATE_W-1:0];
            spg_pkg::REG_STUCK:   gate_cfg.stuck_limit_s = value[spg_pkg::TMO_W-1:0];
            default: ;  // unmapped slots are ignored by the gate
        endcase
    endtask

    task automatic set_config(input logic gate_on, input logic [spg_pkg::DATA_W-1:0] lo,
                              input logic [spg_pkg::DATA_W-1:0] hi,
                              input logic [spg_pkg::DATA_W-1:0] rate,
                              input logic [spg_pkg::DATA_W-1:0] tmo);
        write_reg(spg_pkg::REG_GATE_EN, {31'd0, gate_on});
        write_reg(spg_pkg::REG_MIN, lo);
        write_reg(spg_pkg::REG_MAX, hi);
        write_reg(spg_pkg::REG_RATE, rate);
        write_reg(spg_pkg::REG_STUCK, tmo);
    endtask

    // Step the sensor clock: mostly short hops, sometimes seconds
    function automatic logic [spg_pkg::TIME_W-1:0] advance_clock();
        case ($urandom_range(0, 3))
            0:       sensor_clock_ms += 48'($urandom_range(0, 3));
            1, 2:    sensor_clock_ms += 48'($urandom_range(1, 2500));
            default: sensor_clock_ms += 48'($urandom_range(1, 80)) * 48'd100;
        endcase
        return sensor_clock_ms;
    endfunction

    // One random request: mostly well-formed record/validate streams that
    // probe the range, rate and timeout edges, plus clears and raw noise
    task automatic random_request();
        logic [1:0]                        cmd;
        logic signed [spg_pkg::DATA_W-1:0] rd;
        logic signed [spg_pkg::DATA_W-1:0] offset;
        logic [spg_pkg::TIME_W-1:0]        tms;
        logic [95:0]                       span;
        int unsigned                       pick;
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            cmd = 2'($urandom_range(0, 3));
            rd  = $urandom;
            tms = {16'($urandom), $urandom};
        end else if (pick < 9) begin
            cmd = spg_pkg::CMD_CLEAR;
            rd  = $urandom;
            tms = {16'($urandom), $urandom};
        end else if (pick < 35) begin
            cmd = spg_pkg::CMD_RECORD;
            // a zero stamp right after a clear keeps the rate and timeout tests off
            tms = (!hist.valid && $urandom_range(0, 4) == 0) ? '0 : advance_clock();
            pick = $urandom_range(0, 9);
            if (pick < 5)
                rd = hist.reading;
            else if (pick < 8)
                rd = hist.reading + 32'($urandom_range(0, 200_000)) - 32'd100_000;
            else
                rd = $urandom;
        end else begin
            cmd  = spg_pkg::CMD_VALIDATE;
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                // land one LSB either side of the rate limit
                tms  = advance_clock();
                span = 96'(gate_cfg.max_rate) * 96'(tms - hist.stamp) / 96'd1000;
                if (span > 96'h7FFF_FFFF)
                    span = 96'h7FFF_FFFF;
                offset = 32'(span) + 32'($urandom_range(0, 2)) - 32'd1;
                rd = $urandom_range(0, 1) ? hist.reading + offset : hist.reading - offset;
            end else if (pick < 50) begin
                // land on or just past the stuck timeout
                rd  = hist.reading;
                tms = hist.change_stamp + 48'(gate_cfg.stuck_limit_s) * 48'd1000 +
                      48'($urandom_range(0, 1));
                if (tms > sensor_clock_ms)
                    sensor_clock_ms = tms;
            end else if (pick < 65) begin
                rd  = ($urandom_range(0, 1) ? gate_cfg.range_lo : gate_cfg.range_hi) +
                      32'($urandom_range(0, 2)) - 32'd1;
                tms = advance_clock();
            end else if (pick < 75) begin
                // same or earlier stamp than the last record
                rd  = hist.reading + 32'($urandom_range(0, 2000)) - 32'd1000;
                tms = hist.stamp - 48'($urandom_range(0, 3));
            end else begin
                rd  = $urandom_range(0, 1) ? hist.reading : $urandom;
                tms = advance_clock();
            end
        end
        send_request(cmd, rd, tms);
    endtask

    task automatic run_traffic(input int count, input int stall, input int gaps);
        stall_pct = stall;
        gap_max   = gaps;
        sensor_clock_ms = {16'($urandom_range(0, 16'hFF00)), $urandom};
        for (int i = 0; i < count; i++) begin
            // hold off once per phase until everything in flight has drained
            if (i == count / 2)
                drain_results();
            random_request();
        end
    endtask

    // Out of reset the gate is off: validates fail range, records still land
    task automatic test_disabled_gate();
        send_request(spg_pkg::CMD_VALIDATE, 32'sd0, 48'd100);
        send_request(spg_pkg::CMD_RECORD, 32'sd5, 48'd100);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd5, 48'd200);
        write_reg(spg_pkg::REG_GATE_EN, 32'd1);
    endtask

    // Edges of the physical window, the full signed span, and inverted bounds
    task automatic test_range_bounds();
        write_reg(spg_pkg::REG_MIN, 32'hFFFF_0000);          // -1.0
        write_reg(spg_pkg::REG_MAX, 32'h0064_0000);          // 100.0
        send_request(spg_pkg::CMD_VALIDATE, 32'shFFFF_0000, 48'd300);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh0064_0000, 48'd300);
        send_request(spg_pkg::CMD_VALIDATE, 32'shFFFE_FFFF, 48'd300);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh0064_0001, 48'd300);
        write_reg(spg_pkg::REG_MIN, 32'h8000_0000);
        write_reg(spg_pkg::REG_MAX, 32'h7FFF_FFFF);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh8000_0000, 48'd300);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh7FFF_FFFF, 48'd300);
        write_reg(spg_pkg::REG_MIN, 32'd1);
        write_reg(spg_pkg::REG_MAX, 32'd0);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd0, 48'd300);
        write_reg(spg_pkg::REG_MIN, 32'h8000_0000);
        write_reg(spg_pkg::REG_MAX, 32'h7FFF_FFFF);
    endtask

    // Rate limit: skipped on a zero previous stamp and on no elapsed time,
    // exact at the boundary, and at the largest limit against the widest step
    task automatic test_rate_limit();
        write_reg(spg_pkg::REG_RATE, 32'h0001_0000);         // 1.0 per second
        send_request(spg_pkg::CMD_RECORD, 32'sd0, 48'd0);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh7FFF_FFFF, 48'd10);
        send_request(spg_pkg::CMD_RECORD, 32'sd0, 48'd1000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh0001_0000, 48'd2000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh0001_0001, 48'd2000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh7FFF_FFFF, 48'd1000);
        write_reg(spg_pkg::REG_RATE, 32'h7FFF_FFFF);
        send_request(spg_pkg::CMD_VALIDATE, 32'sh8000_0000, 48'd1001);
        write_reg(spg_pkg::REG_RATE, 32'd0);
    endtask

    // Stuck timeout: boundary, a changed value, the longest timeout, the last
    // timestamp, and no test when the value never changed since a clear
    task automatic test_stuck_timeout();
        write_reg(spg_pkg::REG_STUCK, 32'd1);
        send_request(spg_pkg::CMD_CLEAR, 32'sd0, 48'd0);
        send_request(spg_pkg::CMD_RECORD, 32'sd7, 48'd5000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd7, 48'd6000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd7, 48'd6001);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd8, 48'd9000);
        write_reg(spg_pkg::REG_STUCK, 32'd65535);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd7, 48'hFFFF_FFFF_FFFF);
        send_request(spg_pkg::CMD_CLEAR, 32'sd0, 48'd0);
        send_request(spg_pkg::CMD_RECORD, 32'sd0, 48'd3000);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd0, 48'hFFFF_FFFF_FFFF);
    endtask

    // Unused command and writes to unmapped register slots change nothing
    task automatic test_unused_codes();
        send_request(CMD_UNUSED, 32'shFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        send_request(spg_pkg::CMD_VALIDATE, 32'sd0, 48'hFFFF_FFFF_FFFF);
    endtask

    task automatic test_random_traffic();
        logic [spg_pkg::DATA_W-1:0] only_value;
        // full window, moderate limits, no idling on either side
        set_config(1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h000A_0000, 32'd2);
        run_traffic(250, 0, 0);
        set_config(1'b1, -32'($urandom_range(1, 32'h0100_0000)),
                   32'($urandom_range(1, 32'h0100_0000)),
                   32'($urandom_range(1, 32'h0020_0000)), 32'd1);
        run_traffic(350, 25, 4);
        // widest limits, non-negative readings only
        set_config(1'b1, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd65535);
        run_traffic(250, 60, 8);
        // a single legal value, tightest rate limit
        only_value = $urandom;
        set_config(1'b1, only_value, only_value, 32'd1, 32'd3);
        run_traffic(200, 40, 2);
        // rate and stuck tests off, bounds inverted
        set_config(1'b1, 32'd100, -32'd100, 32'd0, 32'd0);
        run_traffic(100, 10, 3);
        write_reg(spg_pkg::REG_GATE_EN, 32'd0);
        run_traffic(80, 30, 6);
        set_config(1'b1, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'($urandom_range(1, 32'h7FFF_FFFF)), 32'($urandom_range(1, 4)));
        run_traffic(100, 50, 1);
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_disabled_gate();
        test_range_bounds();
        test_rate_limit();
        test_stuck_timeout();
        test_unused_codes();
        test_random_traffic();
        // all requests are in; hold until the last result plus pipeline slack
        drain_results();
        if (mismatch_count == 0)
            $display("sensor_plausibility_gate_tb: done, clean");
        else
            $display("sensor_plausibility_gate_tb: done, errors");
        $finish;
    end

endmodule
